// ===== design/rre_pkg.sv =====
package rre_pkg;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_STREAM = 2'd1;
  localparam logic [1:0] ACT_LOAD   = 2'd2;

  localparam logic [1:0] CFG_DATA_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_SYMBOL_OFFSET = 2'd1;
  localparam logic [1:0] CFG_CODE_OFFSET   = 2'd2;
  localparam logic [1:0] CFG_IMPORT_COUNT  = 2'd3;

  localparam logic [1:0] KIND_SECTION = 2'd1;
  localparam logic [1:0] KIND_IMPORT  = 2'd2;

  localparam logic [3:0] TY_SEL   = 4'h0;
  localparam logic [3:0] TY_ADD8  = 4'h4;
  localparam logic [3:0] TY_REL8  = 4'h5;
  localparam logic [3:0] TY_ADD16 = 4'h6;
  localparam logic [3:0] TY_REL16 = 4'h7;
  localparam logic [3:0] TY_ADD32 = 4'h8;
  localparam logic [3:0] TY_REL32 = 4'h9;
  localparam logic [3:0] TY_FAR16 = 4'hA;
  localparam logic [3:0] TY_FAR32 = 4'hB;

  localparam logic [2:0] PK_STORE_SEL = 3'd0;
  localparam logic [2:0] PK_ADD8      = 3'd1;
  localparam logic [2:0] PK_ADD16     = 3'd2;
  localparam logic [2:0] PK_ADD32     = 3'd3;
  localparam logic [2:0] PK_FAR16     = 3'd4;
  localparam logic [2:0] PK_FAR32     = 3'd5;

  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_SECT   = 3'd1;
  localparam logic [2:0] ERR_SYMBOL = 3'd2;
  localparam logic [2:0] ERR_KIND   = 3'd3;
  localparam logic [2:0] ERR_TYPE   = 3'd4;

  localparam logic [28:0] ITEM_DATA   = 29'd1;
  localparam logic [28:0] ITEM_SYMBOL = 29'd2;
  localparam logic [28:0] ITEM_CODE   = 29'd3;

  localparam logic [15:0] SEL_DATA = 16'h0018;
  localparam logic [15:0] SEL_CODE = 16'h0020;

  localparam logic [28:0] ITEM_MARK14 = 29'h4000;
  localparam logic [28:0] ITEM_MARK21 = 29'h200000;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  stream_byte;
    logic [15:0] record_count;
    logic [31:0] segment_base;
    logic [9:0]  import_index;
    logic [31:0] import_offset;
    logic [15:0] import_selector;
  } item_t;

  typedef struct packed {
    logic [31:0] data_offset;
    logic [31:0] symbol_offset;
    logic [31:0] code_offset;
    logic [10:0] import_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0] patch_location;
    logic [2:0]  patch_kind;
    logic [31:0] add_value;
    logic [15:0] selector_value;
    logic [2:0]  error_code;
    logic        last_record;
  } result_t;

endpackage

// ===== design/rre_core.sv =====
module rre_core #(
  parameter int IMPORT_DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  rre_pkg::item_t  item_i,
  input  rre_pkg::cfg_t   cfg_i,
  output logic            res_valid_o,
  output rre_pkg::result_t res_o
);

  localparam int AW = (IMPORT_DEPTH > 1) ? $clog2(IMPORT_DEPTH) : 1;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_ITEM   = 2'd2;
  localparam logic [1:0] PH_DELTA  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] rec_left_q, rec_left_d;
  logic [31:0] run_loc_q, run_loc_d;
  logic [31:0] loc_base_q, loc_base_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [20:0] item_q, item_d;
  logic [31:0] delta_q, delta_d;
  logic [1:0]  bytes_left_q, bytes_left_d;
  logic        tgt_imp_q, tgt_imp_d;
  logic [31:0] sec_off_q, sec_off_d;
  logic [15:0] sec_sel_q, sec_sel_d;

  logic [47:0] import_mem [IMPORT_DEPTH];
  logic [47:0] rd_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0] idx_ext;

  logic [7:0]  b;
  logic [28:0] v;
  logic        item_fin;
  logic [28:0] item_val;
  logic [20:0] item_step;
  logic [1:0]  bl_step;

  logic [31:0] item_ext, item_m1;
  logic [2:0]  res_err;
  logic [31:0] new_off;
  logic [15:0] new_sel;

  logic [1:0]  shift;
  logic [31:0] delta_new, loc, loc_base, off_t, rel_off, off;
  logic [15:0] sel_t;
  logic        type_ok;
  logic [2:0]  pk;
  logic [31:0] add_v;
  logic [15:0] sel_v;

  assign b = item_i.stream_byte;
  assign v = {item_q, b};

  // item number chaining
  always_comb begin
    item_fin  = 1'b0;
    item_val  = '0;
    item_step = item_q;
    bl_step   = bytes_left_q;
    if (bytes_left_q == 2'd0) begin
      if (!b[7]) begin
        item_fin = 1'b1;
        item_val = {21'd0, b};
      end else begin
        item_step = {14'd0, b[6:0]};
        bl_step   = 2'd1;
      end
    end else if (bytes_left_q == 2'd1 && (v & rre_pkg::ITEM_MARK14) != '0) begin
      item_step = {7'd0, v[13:0]};
      bl_step   = 2'd2;
    end else if (bytes_left_q == 2'd2 && (v & rre_pkg::ITEM_MARK21) != '0) begin
      item_step = v[20:0];
      bl_step   = 2'd3;
    end else begin
      item_fin = 1'b1;
      item_val = v;
    end
  end

  // resolve item against kind
  always_comb begin
    item_ext = {3'd0, item_val};
    item_m1  = item_ext - 32'd1;
    mem_ra   = item_m1[AW-1:0];
    res_err  = rre_pkg::ERR_OK;
    new_off  = '0;
    new_sel  = '0;
    case (hdr_q[3:2])
      rre_pkg::KIND_SECTION: begin
        if (item_val == rre_pkg::ITEM_DATA) begin
          new_off = cfg_i.data_offset;
          new_sel = rre_pkg::SEL_DATA;
        end else if (item_val == rre_pkg::ITEM_SYMBOL) begin
          new_off = cfg_i.symbol_offset;
          new_sel = rre_pkg::SEL_DATA;
        end else if (item_val == rre_pkg::ITEM_CODE) begin
          new_off = cfg_i.code_offset;
          new_sel = rre_pkg::SEL_CODE;
        end else begin
          res_err = rre_pkg::ERR_SECT;
        end
      end
      rre_pkg::KIND_IMPORT: begin
        if (item_val == '0 || item_ext > {21'd0, cfg_i.import_count} ||
            item_ext > 32'(IMPORT_DEPTH)) begin
          res_err = rre_pkg::ERR_SYMBOL;
        end
      end
      default: res_err = rre_pkg::ERR_KIND;
    endcase
  end

  // delta and patch computation
  always_comb begin
    shift     = hdr_q[1:0] - bytes_left_q;
    delta_new = delta_q | (32'(b) << {shift, 3'b000});
    loc       = run_loc_q + delta_new;
    loc_base  = loc_base_q + delta_new;
    off_t     = tgt_imp_q ? rd_q[31:0] : sec_off_q;
    sel_t     = tgt_imp_q ? rd_q[47:32] : sec_sel_q;
    rel_off   = off_t - loc_base;
    type_ok   = 1'b1;
    pk        = rre_pkg::PK_STORE_SEL;
    add_v     = '0;
    sel_v     = '0;
    if (hdr_q[7:4] inside {rre_pkg::TY_REL8, rre_pkg::TY_REL16, rre_pkg::TY_REL32}) begin
      off = rel_off;
    end else begin
      off = off_t;
    end
    case (hdr_q[7:4])
      rre_pkg::TY_SEL: begin
        sel_v = sel_t;
      end
      rre_pkg::TY_ADD8, rre_pkg::TY_REL8: begin
        pk    = rre_pkg::PK_ADD8;
        add_v = {24'd0, off[7:0]};
      end
      rre_pkg::TY_ADD16, rre_pkg::TY_REL16: begin
        pk    = rre_pkg::PK_ADD16;
        add_v = {16'd0, off[15:0]};
      end
      rre_pkg::TY_ADD32, rre_pkg::TY_REL32: begin
        pk    = rre_pkg::PK_ADD32;
        add_v = off;
      end
      rre_pkg::TY_FAR16: begin
        pk    = rre_pkg::PK_FAR16;
        add_v = {16'd0, off[15:0]};
        sel_v = sel_t;
      end
      rre_pkg::TY_FAR32: begin
        pk    = rre_pkg::PK_FAR32;
        add_v = off;
        sel_v = sel_t;
      end
      default: type_ok = 1'b0;
    endcase
  end

  // parse state
  always_comb begin
    phase_d      = phase_q;
    rec_left_d   = rec_left_q;
    run_loc_d    = run_loc_q;
    loc_base_d   = loc_base_q;
    hdr_d        = hdr_q;
    item_d       = item_q;
    delta_d      = delta_q;
    bytes_left_d = bytes_left_q;
    tgt_imp_d    = tgt_imp_q;
    sec_off_d    = sec_off_q;
    sec_sel_d    = sec_sel_q;
    mem_re       = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (step_i) begin
      case (item_i.action)
        rre_pkg::ACT_START: begin
          rec_left_d   = item_i.record_count;
          loc_base_d   = item_i.segment_base;
          run_loc_d    = '0;
          hdr_d        = '0;
          item_d       = '0;
          delta_d      = '0;
          bytes_left_d = '0;
          phase_d      = (item_i.record_count != '0) ? PH_HEADER : PH_IDLE;
        end
        rre_pkg::ACT_STREAM: begin
          case (phase_q)
            PH_HEADER: begin
              hdr_d        = b;
              item_d       = '0;
              bytes_left_d = '0;
              phase_d      = PH_ITEM;
            end
            PH_ITEM: begin
              item_d       = item_step;
              bytes_left_d = bl_step;
              if (item_fin) begin
                if (res_err != rre_pkg::ERR_OK) begin
                  phase_d                = PH_IDLE;
                  res_valid_o            = 1'b1;
                  res_o.error_code       = res_err;
                  res_o.last_record      = 1'b1;
                end else begin
                  phase_d      = PH_DELTA;
                  bytes_left_d = hdr_q[1:0];
                  delta_d      = '0;
                  tgt_imp_d    = (hdr_q[3:2] == rre_pkg::KIND_IMPORT);
                  mem_re       = (hdr_q[3:2] == rre_pkg::KIND_IMPORT);
                  sec_off_d    = new_off;
                  sec_sel_d    = new_sel;
                end
              end
            end
            PH_DELTA: begin
              delta_d = delta_new;
              if (bytes_left_q != 2'd0) begin
                bytes_left_d = bytes_left_q - 2'd1;
              end else if (!type_ok) begin
                phase_d           = PH_IDLE;
                res_valid_o       = 1'b1;
                res_o.error_code  = rre_pkg::ERR_TYPE;
                res_o.last_record = 1'b1;
              end else begin
                run_loc_d            = loc;
                loc_base_d           = loc_base;
                rec_left_d           = rec_left_q - 16'd1;
                phase_d              = (rec_left_d == '0) ? PH_IDLE : PH_HEADER;
                res_valid_o          = 1'b1;
                res_o.patch_location = loc;
                res_o.patch_kind     = pk;
                res_o.add_value      = add_v;
                res_o.selector_value = sel_v;
                res_o.error_code     = rre_pkg::ERR_OK;
                res_o.last_record    = (rec_left_d == '0);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      rec_left_q   <= '0;
      run_loc_q    <= '0;
      loc_base_q   <= '0;
      hdr_q        <= '0;
      item_q       <= '0;
      delta_q      <= '0;
      bytes_left_q <= '0;
      tgt_imp_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      rec_left_q   <= rec_left_d;
      run_loc_q    <= run_loc_d;
      loc_base_q   <= loc_base_d;
      hdr_q        <= hdr_d;
      item_q       <= item_d;
      delta_q      <= delta_d;
      bytes_left_q <= bytes_left_d;
      tgt_imp_q    <= tgt_imp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_off_q <= sec_off_d;
    sec_sel_q <= sec_sel_d;
  end

  // import table
  assign idx_ext = 32'(item_i.import_index);
  assign mem_wa  = idx_ext[AW-1:0];
  assign mem_we  = step_i && item_i.action == rre_pkg::ACT_LOAD &&
                   idx_ext < 32'(IMPORT_DEPTH);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      import_mem[mem_wa] <= {item_i.import_selector, item_i.import_offset};
    end
    if (mem_re) begin
      rd_q <= import_mem[mem_ra];
    end
  end

endmodule

// ===== design/relocation_record_engine.sv =====
// channel | dir | handshake                 | payload
// in      | in  | in_valid_i / in_stall_o   | in_action_i .. in_import_selector_i
// out     | out | out_valid_o / out_stall_i | out_patch_location_o .. out_last_record_o
// cfg     | in  | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// one beat per cycle while in_stall_o is low; a beat is held in the input reg and its result in the result reg
// an import entry read is issued on the last item byte and used on the last delta byte
// reset clears all control state at once; the import table is not cleared
// in_stall_o rises only when the input reg and the result reg are both full and
// out_stall_i is high
module relocation_record_engine #(
  parameter int IMPORT_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_action_i,
  input  logic [7:0]  in_stream_byte_i,
  input  logic [15:0] in_record_count_i,
  input  logic [31:0] in_segment_base_i,
  input  logic [9:0]  in_import_index_i,
  input  logic [31:0] in_import_offset_i,
  input  logic [15:0] in_import_selector_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_patch_location_o,
  output logic [2:0]  out_patch_kind_o,
  output logic [31:0] out_add_value_o,
  output logic [15:0] out_selector_value_o,
  output logic [2:0]  out_error_code_o,
  output logic        out_last_record_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  rre_pkg::cfg_t    cfg_q;
  rre_pkg::item_t   in_q;
  logic             in_valid_q;
  logic             out_valid_q;
  rre_pkg::result_t res_q;
  rre_pkg::result_t core_res;
  logic             core_valid;
  logic             adv, step;

  assign adv        = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rre_pkg::CFG_DATA_OFFSET:   cfg_q.data_offset   <= cfg_wdata_i;
        rre_pkg::CFG_SYMBOL_OFFSET: cfg_q.symbol_offset <= cfg_wdata_i;
        rre_pkg::CFG_CODE_OFFSET:   cfg_q.code_offset   <= cfg_wdata_i;
        rre_pkg::CFG_IMPORT_COUNT:  cfg_q.import_count  <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q.action          <= in_action_i;
      in_q.stream_byte     <= in_stream_byte_i;
      in_q.record_count    <= in_record_count_i;
      in_q.segment_base    <= in_segment_base_i;
      in_q.import_index    <= in_import_index_i;
      in_q.import_offset   <= in_import_offset_i;
      in_q.import_selector <= in_import_selector_i;
    end
  end

  rre_core #(
    .IMPORT_DEPTH(IMPORT_DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .cfg_i      (cfg_q),
    .res_valid_o(core_valid),
    .res_o      (core_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= step && core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && core_valid) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_patch_location_o = res_q.patch_location;
  assign out_patch_kind_o     = res_q.patch_kind;
  assign out_add_value_o      = res_q.add_value;
  assign out_selector_value_o = res_q.selector_value;
  assign out_error_code_o     = res_q.error_code;
  assign out_last_record_o    = res_q.last_record;

  a_err_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_error_code_o != rre_pkg::ERR_OK |->
      out_last_record_o && out_patch_location_o == '0 && out_add_value_o == '0 &&
      out_selector_value_o == '0 && out_patch_kind_o == rre_pkg::PK_STORE_SEL)
    else $error("error beat carries patch data");

  a_plain_no_sel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_patch_kind_o == rre_pkg::PK_ADD8 ||
      out_patch_kind_o == rre_pkg::PK_ADD16 || out_patch_kind_o == rre_pkg::PK_ADD32) |->
      out_selector_value_o == '0)
    else $error("selector on plain add");

  a_add8_width : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_patch_kind_o == rre_pkg::PK_ADD8 |-> out_add_value_o[31:8] == '0)
    else $error("add8 value too wide");

  a_add16_width : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_patch_kind_o == rre_pkg::PK_ADD16 ||
      out_patch_kind_o == rre_pkg::PK_FAR16) |-> out_add_value_o[31:16] == '0)
    else $error("add16 value too wide");

endmodule
